// ===== rtl/tfb_pkg.sv =====
// Shared types, constants and the CRC-8 byte step of the telemetry frame builder.
package tfb_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned FRAME_BYTES   = 16;
    localparam int unsigned CRC_SPAN      = FRAME_BYTES - 1;
    localparam int unsigned BODY_W        = CRC_SPAN * BYTE_W;
    localparam int unsigned IDX_W         = $clog2(FRAME_BYTES);
    localparam int unsigned CFG_INDEX_W   = 8;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;
    localparam logic [IDX_W-1:0]  CRC_POS  = IDX_W'(CRC_SPAN);

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_BYTE     = 8'd2;

    // Frame body, byte 0 in bits [7:0], byte 14 in the top byte.
    typedef struct packed {
        logic [BODY_W-1:0] body;
    } t_frame;

    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/telemetry_frame_builder_crc8_core.sv =====
// Top level: telemetry frame builder with CRC-8, front end, queue and serializer.
// Accepted items enter the queue; the serializer pops each and sends its 16 bytes back to back.
// The serializer emits one byte per cycle while a frame is active.
// The queue holds QUEUE_DEPTH frames; busy is high while it is full or reset is asserted.
// Reset (synchronous, active low) clears the header/flag registers, the queue and the serializer.
// Results cannot be stalled: each byte is valid for exactly one cycle.
module telemetry_frame_builder_crc8_core #(
    parameter int unsigned QUEUE_DEPTH = tfb_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tfb_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tfb_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [tfb_pkg::WORD_W-1:0]       i_frame_count,
    input  logic [tfb_pkg::WORD_W-1:0]       i_breath_bits,
    input  logic [tfb_pkg::WORD_W-1:0]       i_heart_bits,
    output logic                             o_strobe,
    output logic [tfb_pkg::BYTE_W-1:0]       o_frame_byte,
    output logic                             o_last_byte
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    tfb_pkg::t_frame w_in_frame;
    tfb_pkg::t_frame w_out_frame;

    tfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .i_full        (w_full),
        .i_frame_count (i_frame_count),
        .i_breath_bits (i_breath_bits),
        .i_heart_bits  (i_heart_bits),
        .o_push        (w_push),
        .o_frame       (w_in_frame)
    );

    tfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_in_frame),
        .i_pop   (w_pop),
        .o_frame (w_out_frame),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_frame      (w_out_frame),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    assign o_busy = w_full || !i_rst_n;

endmodule

// ===== rtl/tfb_front.sv =====
// Front end: configuration registers, item acceptance and frame body assembly.
module tfb_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tfb_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tfb_pkg::BYTE_W-1:0]         i_cfg_data,
    input  logic                               i_start,
    input  logic                               i_full,
    input  logic [tfb_pkg::WORD_W-1:0]         i_frame_count,
    input  logic [tfb_pkg::WORD_W-1:0]         i_breath_bits,
    input  logic [tfb_pkg::WORD_W-1:0]         i_heart_bits,
    output logic                               o_push,
    output tfb_pkg::t_frame                    o_frame
);

    logic [tfb_pkg::BYTE_W-1:0] r_header_first;
    logic [tfb_pkg::BYTE_W-1:0] r_header_second;
    logic [tfb_pkg::BYTE_W-1:0] r_flag_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= '0;
            r_header_second <= '0;
            r_flag_byte     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfb_pkg::CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                tfb_pkg::CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                tfb_pkg::CFG_FLAG_BYTE:     r_flag_byte     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_push       = i_rst_n && i_start && !i_full;
    assign o_frame.body = {i_heart_bits, i_breath_bits, i_frame_count,
                           r_flag_byte, r_header_second, r_header_first};

endmodule

// ===== rtl/tfb_queue.sv =====
// Short frame queue between the front end and the serializer.
module tfb_queue #(
    parameter int unsigned DEPTH = tfb_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfb_pkg::t_frame i_frame,
    input  logic            i_pop,
    output tfb_pkg::t_frame o_frame,
    output logic            o_full,
    output logic            o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tfb_pkg::t_frame  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_frame = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// ===== rtl/tfb_back.sv =====
// Serializer: while a frame is active, emits one frame byte per cycle and the running CRC-8 as the last byte.
module tfb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  tfb_pkg::t_frame            i_frame,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic [tfb_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                       o_last_byte
);

    logic                        r_active;
    logic [tfb_pkg::IDX_W-1:0]   r_idx;
    logic [tfb_pkg::BODY_W-1:0]  r_data;
    logic [tfb_pkg::BYTE_W-1:0]  r_crc;
    logic                        r_strobe;
    logic [tfb_pkg::BYTE_W-1:0]  r_byte;
    logic                        r_last;
    logic                        w_at_crc;
    logic [tfb_pkg::BYTE_W-1:0]  w_cur;

    assign w_at_crc = (r_idx == tfb_pkg::CRC_POS);
    assign w_cur    = w_at_crc ? r_crc : r_data[tfb_pkg::BYTE_W-1:0];
    assign o_pop    = (!r_active || w_at_crc) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= r_active;
            r_last   <= r_active && w_at_crc;
            if (o_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (r_active) begin
                r_idx <= r_idx + 1'b1;
                if (w_at_crc) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= w_cur;
        if (o_pop) begin
            r_data <= i_frame.body;
            r_crc  <= tfb_pkg::CRC_INIT;
        end else if (r_active) begin
            r_data <= r_data >> tfb_pkg::BYTE_W;
            r_crc  <= tfb_pkg::crc8_step(r_crc, r_data[tfb_pkg::BYTE_W-1:0]);
        end
    end

    assign o_strobe     = r_strobe;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

`ifndef SYNTHESIS
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_strobe)
        else $error("last byte without strobe");
    a_mid_frame_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_at_crc) |=> r_active)
        else $error("frame stopped before its last byte");
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && w_at_crc) |=> (r_last && r_strobe))
        else $error("crc byte not marked last");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the telemetry frame builder: random and directed CRC-8 frames.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned FRAME_LEN = tfb_pkg::FRAME_BYTES;
    localparam int unsigned BODY_LEN  = tfb_pkg::CRC_SPAN;

    localparam logic [tfb_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_LOW = 8'd3;
    localparam logic [tfb_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_TOP = 8'hFF;

    typedef enum logic [1:0] {
        REC_ITEM,
        REC_CFG,
        REC_DRAIN
    } t_record_kind;

    typedef struct {
        t_record_kind                    kind;
        logic [tfb_pkg::WORD_W-1:0]      count;
        logic [tfb_pkg::WORD_W-1:0]      breath;
        logic [tfb_pkg::WORD_W-1:0]      heart;
        logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index;
        logic [tfb_pkg::BYTE_W-1:0]      cfg_data;
        int unsigned                     idle_pct;
    } t_record;

    typedef struct {
        logic [tfb_pkg::BYTE_W-1:0] value;
        logic                       last;
    } t_frame_byte;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [tfb_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [tfb_pkg::BYTE_W-1:0]      i_cfg_data = '0;
    logic                            i_start = 1'b0;
    logic [tfb_pkg::WORD_W-1:0]      i_frame_count = '0;
    logic [tfb_pkg::WORD_W-1:0]      i_breath_bits = '0;
    logic [tfb_pkg::WORD_W-1:0]      i_heart_bits = '0;
    logic                            o_busy;
    logic                            o_strobe;
    logic [tfb_pkg::BYTE_W-1:0]      o_frame_byte;
    logic                            o_last_byte;

    t_record     record_q[$];
    t_frame_byte pending_bytes[$];

    logic [tfb_pkg::BYTE_W-1:0] hdr_first_reg = '0;
    logic [tfb_pkg::BYTE_W-1:0] hdr_second_reg = '0;
    logic [tfb_pkg::BYTE_W-1:0] flag_reg = '0;

    int unsigned issued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count = 0;
    bit          holding = 1'b0;

    telemetry_frame_builder_crc8_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_frame_count (i_frame_count),
        .i_breath_bits (i_breath_bits),
        .i_heart_bits  (i_heart_bits),
        .o_strobe      (o_strobe),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ data[k];
            c = {c[6:0], 1'b0} ^ (fb ? tfb_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void predict_frame(
        input logic [31:0] count,
        input logic [31:0] breath,
        input logic [31:0] heart
    );
        logic [7:0]  body[FRAME_LEN];
        logic [7:0]  crc;
        t_frame_byte fb;
        body[0] = hdr_first_reg;
        body[1] = hdr_second_reg;
        body[2] = flag_reg;
        for (int i = 0; i < 4; i++) begin
            body[3 + i]  = count[8*i +: 8];
            body[7 + i]  = breath[8*i +: 8];
            body[11 + i] = heart[8*i +: 8];
        end
        crc = tfb_pkg::CRC_INIT;
        for (int i = 0; i < BODY_LEN; i++) begin
            crc = crc8_byte(crc, body[i]);
        end
        body[BODY_LEN] = crc;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fb.value = body[i];
            fb.last  = (i == FRAME_LEN - 1);
            pending_bytes.push_back(fb);
        end
    endfunction

    // Drive on the falling edge; hold start until the item is taken.
    always @(negedge i_clk) begin
        t_record                         head;
        logic                            start_v;
        logic                            we_v;
        logic [tfb_pkg::CFG_INDEX_W-1:0] idx_v;
        logic [tfb_pkg::BYTE_W-1:0]      dat_v;
        logic [31:0]                     cnt_v;
        logic [31:0]                     br_v;
        logic [31:0]                     ht_v;
        start_v = i_start;
        we_v    = 1'b0;
        idx_v   = i_cfg_index;
        dat_v   = i_cfg_data;
        cnt_v   = i_frame_count;
        br_v    = i_breath_bits;
        ht_v    = i_heart_bits;
        if (i_rst_n) begin
            if (holding && accepted_count == issued_count) begin
                holding = 1'b0;
                start_v = 1'b0;
            end
            if (!holding) begin
                cnt_v = $urandom;
                br_v  = $urandom;
                ht_v  = $urandom;
                if (record_q.size() != 0) begin
                    head = record_q[0];
                    case (head.kind)
                        REC_CFG: begin
                            we_v  = 1'b1;
                            idx_v = head.cfg_index;
                            dat_v = head.cfg_data;
                            record_q.delete(0);
                        end
                        REC_DRAIN: begin
                            if (pending_bytes.size() == 0) begin
                                record_q.delete(0);
                            end
                        end
                        default: begin
                            if ($urandom_range(99) >= head.idle_pct) begin
                                start_v = 1'b1;
                                cnt_v   = head.count;
                                br_v    = head.breath;
                                ht_v    = head.heart;
                                holding = 1'b1;
                                issued_count++;
                                record_q.delete(0);
                            end
                        end
                    endcase
                end
            end
        end
        i_start       <= start_v;
        i_cfg_we      <= we_v;
        i_cfg_index   <= idx_v;
        i_cfg_data    <= dat_v;
        i_frame_count <= cnt_v;
        i_breath_bits <= br_v;
        i_heart_bits  <= ht_v;
    end

    // Check bytes first, then track config writes and accepted items.
    always @(posedge i_clk) begin
        t_frame_byte exp_b;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_bytes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected byte %02h last %0b", $time, o_frame_byte,
                             o_last_byte);
                end else begin
                    exp_b = pending_bytes.pop_front();
                    if (o_frame_byte !== exp_b.value) begin
                        error_count++;
                        $display("%0t: frame_byte expected %02h actual %02h", $time,
                                 exp_b.value, o_frame_byte);
                    end
                    if (o_last_byte !== exp_b.last) begin
                        error_count++;
                        $display("%0t: last_byte expected %0b actual %0b", $time,
                                 exp_b.last, o_last_byte);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tfb_pkg::CFG_HEADER_FIRST:  hdr_first_reg  = i_cfg_data;
                    tfb_pkg::CFG_HEADER_SECOND: hdr_second_reg = i_cfg_data;
                    tfb_pkg::CFG_FLAG_BYTE:     flag_reg       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                predict_frame(i_frame_count, i_breath_bits, i_heart_bits);
                accepted_count++;
            end
        end
    end

    task automatic add_item(input logic [31:0] c, input logic [31:0] b, input logic [31:0] h,
                            input int unsigned pct);
        t_record r;
        r.kind      = REC_ITEM;
        r.count     = c;
        r.breath    = b;
        r.heart     = h;
        r.cfg_index = '0;
        r.cfg_data  = '0;
        r.idle_pct  = pct;
        record_q.push_back(r);
    endtask

    task automatic add_cfg(input logic [7:0] idx, input logic [7:0] val);
        t_record r;
        r.kind      = REC_CFG;
        r.count     = '0;
        r.breath    = '0;
        r.heart     = '0;
        r.cfg_index = idx;
        r.cfg_data  = val;
        r.idle_pct  = 0;
        record_q.push_back(r);
    endtask

    task automatic add_drain();
        t_record r;
        r.kind      = REC_DRAIN;
        r.count     = '0;
        r.breath    = '0;
        r.heart     = '0;
        r.cfg_index = '0;
        r.cfg_data  = '0;
        r.idle_pct  = 0;
        record_q.push_back(r);
    endtask

    task automatic configure(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] fl);
        add_drain();
        add_cfg(tfb_pkg::CFG_HEADER_FIRST, h1);
        add_cfg(tfb_pkg::CFG_HEADER_SECOND, h2);
        add_cfg(tfb_pkg::CFG_FLAG_BYTE, fl);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {1'($urandom), 8'hFF, 23'($urandom)};
            3: return {1'($urandom), 8'h00, 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_cfg();
        case ($urandom_range(4))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int unsigned phase_pct[8];
        int unsigned pause_at;
        phase_pct = '{0, 50, 24, 0, 50, 24, 0, 24};

        // Reset values of the header and flag registers.
        add_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_item(32'h0123_4567, 32'h7F80_0000, 32'h7FC0_0001, 0);
        add_item(32'h89AB_CDEF, 32'h0000_0001, 32'h8000_0000, 0);

        configure(8'hFF, 8'hFF, 8'hFF);
        add_item(32'hFFFF_FFFF, 32'hFF80_0000, 32'h807F_FFFF, 0);
        add_item(32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 0);
        add_item(32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 0);

        // Writes to unused indexes leave the registers unchanged.
        add_drain();
        add_cfg(CFG_NO_REG_LOW, 8'h12);
        add_cfg(CFG_NO_REG_TOP, 8'h34);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_item(32'h5555_5555, 32'h3F80_0000, 32'hC2C8_0000, 0);

        configure(8'h00, 8'hFF, 8'h5A);
        add_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        add_item(32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h0080_0000, 0);
        add_item(32'h0000_0001, 32'h4120_0000, 32'h42A0_0000, 0);

        for (int p = 0; p < 8; p++) begin
            configure(rand_cfg(), rand_cfg(), rand_cfg());
            if ($urandom_range(1)) begin
                add_cfg(8'($urandom_range(255, 3)), rand_cfg());
            end
            pause_at = $urandom_range(40, 5);
            for (int n = 0; n < 45; n++) begin
                if (n == pause_at) begin
                    add_drain();
                end
                add_item(rand_word(), rand_word(), rand_word(), phase_pct[p]);
            end
        end

        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (record_q.size() != 0 || holding || pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            error_count++;
            $display("%0t: %0d bytes expected but never seen", $time, pending_bytes.size());
        end
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule
